[design/sps_pkg.sv]
// ----------------------------------------------------------------------------
// sps_pkg
// Shared constants, types and helpers of the multi-channel sine oscillator.
// ----------------------------------------------------------------------------
package sps_pkg;

  localparam int CHANNELS     = 8;
  localparam int TABLE_BITS   = 10;
  localparam int SLOT_W       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  localparam int CH_W         = 3;
  localparam int FREQ_W       = 24;
  localparam int PHASE_W      = 32;
  localparam int SAMPLE_W     = 16;
  localparam int MAG_W        = SAMPLE_W - 1;
  localparam int SCALE_W      = 40;
  localparam logic [SCALE_W-1:0] SCALE_RESET = 40'd6382696410;

  // frequency times scale, split in two partial products
  localparam int SPLIT        = 20;
  localparam int PART_W       = FREQ_W + SPLIT + 1;
  localparam int PROD_W       = FREQ_W + SCALE_W;
  localparam int STEP_LSB     = 24;

  localparam int QUARTER_BITS = TABLE_BITS - 2;
  localparam int QUARTER      = 1 << QUARTER_BITS;
  localparam int QIDX_W       = QUARTER_BITS + 1;
  localparam int AMPLITUDE    = 32767;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] Q30_ONE     = 64'd1073741824;

  localparam int OUT_DEPTH    = 8;
  localparam int OUT_PTR_W    = $clog2(OUT_DEPTH);
  localparam int OUT_CNT_W    = $clog2(OUT_DEPTH + 1);

  // register file: one 40-bit register, 8-byte spacing
  localparam int PADDR_W      = 4;
  localparam int PDATA_W      = 64;
  localparam int REG_LSB      = 3;
  localparam logic REG_TURN_SCALE = 1'b0;

  typedef struct packed {
    logic [CH_W-1:0]     out_channel;
    logic [SAMPLE_W-1:0] sine_sample;
  } out_entry_t;

  // channel folded onto the accumulators that exist
  function automatic logic [SLOT_W-1:0] slot_of(input logic [CH_W-1:0] ch);
    logic [CH_W-1:0] r;
    r = ch;
    for (int i = 0; i < (1 << CH_W) - 1; i++) begin
      if (int'(r) >= CHANNELS) begin
        r = r - CH_W'(CHANNELS);
      end
    end
    return SLOT_W'(r);
  endfunction

  // quarter-wave sine entry, q30 taylor series, evaluated at elaboration
  function automatic logic [MAG_W-1:0] quarter_sine(input int m);
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic [63:0]        v;
    logic signed [63:0] acc;
    x    = (HALF_PI_Q30 * 64'(m) + ((64'd1 << QUARTER_BITS) >> 1)) >> QUARTER_BITS;
    x2   = (x * x) >> 30;
    term = x;
    acc  = $signed(x);
    for (int n = 1; n <= 7; n++) begin
      term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
      if (n[0]) begin
        acc = acc - $signed(term);
      end else begin
        acc = acc + $signed(term);
      end
    end
    if (acc < 0) begin
      acc = '0;
    end
    v = (64'(acc) * 64'(AMPLITUDE) + (Q30_ONE >> 1)) >> 30;
    if (v > 64'(AMPLITUDE)) begin
      v = 64'(AMPLITUDE);
    end
    return MAG_W'(v);
  endfunction

endpackage

[design/sps_if.sv]
// ----------------------------------------------------------------------------
// sps_if
// Valid/ready channels of the sine oscillator: request items and samples.
// ----------------------------------------------------------------------------
interface sps_req_if;
  logic                                 valid;
  logic                                 ready;
  logic [sps_pkg::CH_W-1:0]             channel;
  logic signed [sps_pkg::FREQ_W-1:0]    frequency;
  logic [sps_pkg::PHASE_W-1:0]          phase_shift;
  logic                                 reset_trigger;

  modport source (output valid, channel, frequency, phase_shift, reset_trigger,
                  input ready);
  modport sink   (input valid, channel, frequency, phase_shift, reset_trigger,
                  output ready);
endinterface

interface sps_rsp_if;
  logic                                 valid;
  logic                                 ready;
  logic [sps_pkg::CH_W-1:0]             out_channel;
  logic signed [sps_pkg::SAMPLE_W-1:0]  sine_sample;

  modport source (output valid, out_channel, sine_sample, input ready);
  modport sink   (input valid, out_channel, sine_sample, output ready);
endinterface

[design/sps_ram.sv]
// ----------------------------------------------------------------------------
// sps_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module sps_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  logic                                        clk,
  input  logic                                        we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                            wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                            rdata
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];

  // read returns the old contents on a same-address write
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[design/sine_phase_oscillator_unit.sv]
// ----------------------------------------------------------------------------
// sine_phase_oscillator_unit
// Multi-channel sine DDS: per-channel phase accumulators in a RAM, a quarter
// wave sine table and an output queue.
// ----------------------------------------------------------------------------
//   channel | dir | payload                                         | role
//   req     | in  | channel, frequency, phase_shift, reset_trigger  | one item
//   rsp     | out | out_channel, sine_sample                        | one sample
//   apb     | in  | turn_scale at byte address 0 (64-bit data)      | config
//
// One item per cycle while req.ready is high; samples pass the pipeline and the
// output queue. The rate is set by the phase RAM read-modify-write, bypassed from
// the write-back stage and from the write of the cycle before.
// Reset clears the accumulators at once through per-entry valid bits.
// An 8-entry output queue absorbs stalls; req.ready drops only when 8 items
// are outstanding.
// ----------------------------------------------------------------------------
module sine_phase_oscillator_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [sps_pkg::PADDR_W-1:0]   paddr,
  input  logic [sps_pkg::PDATA_W-1:0]   pwdata,
  output logic [sps_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready,
  sps_req_if.sink                       req,
  sps_rsp_if.source                     rsp
);

  // configuration
  logic [sps_pkg::SCALE_W-1:0] turn_scale;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      turn_scale <= sps_pkg::SCALE_RESET;
    end else if (psel && penable && pwrite &&
                 paddr[sps_pkg::REG_LSB] == sps_pkg::REG_TURN_SCALE) begin
      turn_scale <= pwdata[sps_pkg::SCALE_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[sps_pkg::REG_LSB] == sps_pkg::REG_TURN_SCALE) begin
      prdata = {{(sps_pkg::PDATA_W - sps_pkg::SCALE_W){1'b0}}, turn_scale};
    end
  end

  // flow control
  logic                          in_fire;
  logic                          out_fire;
  logic [sps_pkg::OUT_CNT_W-1:0] pending;

  assign req.ready = (pending < sps_pkg::OUT_CNT_W'(sps_pkg::OUT_DEPTH));
  assign in_fire   = req.valid && req.ready;
  assign out_fire  = rsp.valid && rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else if (in_fire && !out_fire) begin
      pending <= pending + 1'b1;
    end else if (!in_fire && out_fire) begin
      pending <= pending - 1'b1;
    end
  end

  // stage 0: partial products and phase read
  logic [sps_pkg::SLOT_W-1:0]        slot0;
  logic signed [sps_pkg::PART_W-1:0] part_lo0;
  logic signed [sps_pkg::PART_W-1:0] part_hi0;

  assign slot0    = sps_pkg::slot_of(req.channel);
  assign part_lo0 = req.frequency *
                    $signed({1'b0, turn_scale[sps_pkg::SPLIT-1:0]});
  assign part_hi0 = req.frequency *
                    $signed({1'b0, turn_scale[sps_pkg::SCALE_W-1:sps_pkg::SPLIT]});

  // stage 1 registers
  logic                              v1;
  logic [sps_pkg::CH_W-1:0]          ch1;
  logic [sps_pkg::SLOT_W-1:0]        slot1;
  logic [sps_pkg::PHASE_W-1:0]       offset1;
  logic                              trig1;
  logic signed [sps_pkg::PART_W-1:0] part_lo1;
  logic signed [sps_pkg::PART_W-1:0] part_hi1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= in_fire;
    end
  end

  always_ff @(posedge clk) begin
    ch1      <= req.channel;
    slot1    <= slot0;
    offset1  <= req.phase_shift;
    trig1    <= req.reset_trigger;
    part_lo1 <= part_lo0;
    part_hi1 <= part_hi0;
  end

  // phase RAM and bypass state
  logic                         ram_we;
  logic [sps_pkg::PHASE_W-1:0]  ram_rdata;
  logic [sps_pkg::CHANNELS-1:0] slot_vld;
  logic                         lw_v;
  logic [sps_pkg::SLOT_W-1:0]   lw_slot;
  logic [sps_pkg::PHASE_W-1:0]  lw_data;

  // stage 2 registers
  logic                        v2;
  logic [sps_pkg::CH_W-1:0]    ch2;
  logic [sps_pkg::SLOT_W-1:0]  slot2;
  logic [sps_pkg::PHASE_W-1:0] offset2;
  logic [sps_pkg::PHASE_W-1:0] phase2;
  logic [sps_pkg::PHASE_W-1:0] step2;
  logic [sps_pkg::PHASE_W-1:0] new2;

  // stage 1: bypass select, reset trigger, step sum
  logic [sps_pkg::PHASE_W-1:0]       phase_fwd1;
  logic [sps_pkg::PHASE_W-1:0]       phase1;
  logic signed [sps_pkg::PROD_W-1:0] prod_lo1;
  logic signed [sps_pkg::PROD_W-1:0] prod_hi1;
  logic signed [sps_pkg::PROD_W-1:0] prod1;

  always_comb begin
    if (v2 && slot2 == slot1) begin
      phase_fwd1 = new2;
    end else if (lw_v && lw_slot == slot1) begin
      phase_fwd1 = lw_data;
    end else if (slot_vld[slot1]) begin
      phase_fwd1 = ram_rdata;
    end else begin
      phase_fwd1 = '0;
    end
    phase1   = trig1 ? '0 : phase_fwd1;
    prod_lo1 = part_lo1;
    prod_hi1 = part_hi1;
    prod1    = prod_lo1 + (prod_hi1 <<< sps_pkg::SPLIT);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    ch2     <= ch1;
    slot2   <= slot1;
    offset2 <= offset1;
    phase2  <= phase1;
    step2   <= prod1[sps_pkg::STEP_LSB +: sps_pkg::PHASE_W];
  end

  // stage 2: accumulate, write back, table address
  logic [sps_pkg::PHASE_W-1:0]      sum2;
  logic [sps_pkg::TABLE_BITS-1:0]   idx2;
  logic [sps_pkg::QIDX_W-1:0]       qidx2;

  assign new2   = phase2 + step2;
  assign ram_we = v2;
  assign sum2   = phase2 + offset2;
  assign idx2   = sum2[sps_pkg::PHASE_W-1 -: sps_pkg::TABLE_BITS];
  // odd quadrants run the quarter table backwards
  assign qidx2  = idx2[sps_pkg::TABLE_BITS-2] ?
                  (sps_pkg::QIDX_W'(sps_pkg::QUARTER) -
                   {1'b0, idx2[sps_pkg::QUARTER_BITS-1:0]}) :
                  {1'b0, idx2[sps_pkg::QUARTER_BITS-1:0]};

  sps_ram #(
    .WIDTH (sps_pkg::PHASE_W),
    .DEPTH (sps_pkg::CHANNELS)
  ) u_phase_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (slot2),
    .wdata (new2),
    .raddr (slot0),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_vld <= '0;
      lw_v     <= 1'b0;
    end else begin
      if (ram_we) begin
        slot_vld[slot2] <= 1'b1;
      end
      lw_v <= ram_we;
    end
  end

  always_ff @(posedge clk) begin
    lw_slot <= slot2;
    lw_data <= new2;
  end

  // stage 3 registers
  logic                        v3;
  logic [sps_pkg::CH_W-1:0]    ch3;
  logic [sps_pkg::QIDX_W-1:0]  qidx3;
  logic                        neg3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    ch3   <= ch2;
    qidx3 <= qidx2;
    neg3  <= idx2[sps_pkg::TABLE_BITS-1];
  end

  // stage 3: quarter-wave table and sign
  logic [sps_pkg::MAG_W-1:0]    qsine [0:sps_pkg::QUARTER];
  logic [sps_pkg::SAMPLE_W-1:0] mag3;
  logic [sps_pkg::SAMPLE_W-1:0] sample3;

  for (genvar k = 0; k <= sps_pkg::QUARTER; k++) begin : g_qsine
    assign qsine[k] = sps_pkg::quarter_sine(k);
  end

  assign mag3    = {1'b0, qsine[qidx3]};
  assign sample3 = neg3 ? (~mag3 + 1'b1) : mag3;

  // output queue
  sps_pkg::out_entry_t           oq [0:sps_pkg::OUT_DEPTH-1];
  logic [sps_pkg::OUT_PTR_W-1:0] wr_ptr;
  logic [sps_pkg::OUT_PTR_W-1:0] rd_ptr;
  logic [sps_pkg::OUT_CNT_W-1:0] oq_cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      oq_cnt <= '0;
    end else begin
      if (v3) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (out_fire) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (v3 && !out_fire) begin
        oq_cnt <= oq_cnt + 1'b1;
      end else if (!v3 && out_fire) begin
        oq_cnt <= oq_cnt - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (v3) begin
      oq[wr_ptr] <= '{out_channel: ch3, sine_sample: sample3};
    end
  end

  assign rsp.valid       = (oq_cnt != '0);
  assign rsp.out_channel = oq[rd_ptr].out_channel;
  assign rsp.sine_sample = $signed(oq[rd_ptr].sine_sample);

  // every outstanding item is either in flight or queued
  a_pending_balance : assert property (@(posedge clk) disable iff (rst)
    pending == sps_pkg::OUT_CNT_W'($countones({v1, v2, v3})) + oq_cnt)
    else $error("outstanding count out of step with pipeline and queue");

  // a full queue never sees a push without a pop
  a_queue_no_overflow : assert property (@(posedge clk) disable iff (rst)
    (oq_cnt == sps_pkg::OUT_CNT_W'(sps_pkg::OUT_DEPTH)) |-> (!v3 || out_fire))
    else $error("output queue overflow");

  // back-to-back items on one channel see the phase just written back
  a_bypass_latest : assert property (@(posedge clk) disable iff (rst)
    (v1 && v2 && slot1 == slot2 && !trig1) |=> (phase2 == $past(new2)))
    else $error("phase bypass missed the write-back value");

  // a triggered item starts from phase zero
  a_trigger_clears : assert property (@(posedge clk) disable iff (rst)
    (v1 && trig1) |=> (v2 && sum2 == offset2))
    else $error("reset trigger did not clear the phase");

endmodule
